### hw/rtl/wph_pkg.sv
// ----------------------------------------------------------------------------
// WAV PCM header parser package
// Shared types and constants for the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
package wph_pkg;

  localparam int unsigned HeaderLen = 44;
  localparam int unsigned PosW      = 6;
  localparam int unsigned SizeW     = 31;
  localparam int unsigned OutDataW  = 112;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6d66;
  localparam logic [31:0] TagData = 32'h6174_6164;
  localparam logic [31:0] FmtSize = 32'd16;
  localparam logic [15:0] FmtPcm  = 16'd1;
  localparam logic [15:0] MonoCh  = 16'd1;
  localparam logic [15:0] Width8  = 16'd8;

  localparam logic [PosW-1:0] PosRiffEnd  = PosW'(3);
  localparam logic [PosW-1:0] PosWaveEnd  = PosW'(11);
  localparam logic [PosW-1:0] PosFmtEnd   = PosW'(15);
  localparam logic [PosW-1:0] PosFsizeEnd = PosW'(19);
  localparam logic [PosW-1:0] PosFtagEnd  = PosW'(21);
  localparam logic [PosW-1:0] PosChanEnd  = PosW'(23);
  localparam logic [PosW-1:0] PosRateEnd  = PosW'(27);
  localparam logic [PosW-1:0] PosWidthEnd = PosW'(35);
  localparam logic [PosW-1:0] PosDtagEnd  = PosW'(39);
  localparam logic [PosW-1:0] PosDsizeEnd = PosW'(43);

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_RIFF   = 3'd1,
    ERR_NO_WAVE   = 3'd2,
    ERR_NO_FMT    = 3'd3,
    ERR_FMT_SIZE  = 3'd4,
    ERR_NOT_PCM   = 3'd5,
    ERR_DATA_SIZE = 3'd6
  } err_e;

  typedef struct packed {
    logic             payload_valid;
    logic [7:0]       payload_byte;
    logic             payload_last;
    logic             header_ok;
    err_e             error_code;
    logic             tag_warning;
    logic [15:0]      channels;
    logic [15:0]      bits_per_sample;
    logic [31:0]      sample_rate;
    logic [SizeW-1:0] data_size;
    logic [1:0]       format_code;
  } result_t;

endpackage

### hw/rtl/wph_core.sv
// ----------------------------------------------------------------------------
// WAV PCM header parser core
// Holds the parse state and forms the result for the byte being stepped in.
// ----------------------------------------------------------------------------
module wph_core
  import wph_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] in_byte_i,
  input  logic       start_i,
  output result_t    result_o
);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [31:0]      shift_q, shift_d;
  logic [15:0]      chan_q, chan_d;
  logic [15:0]      width_q, width_d;
  logic [31:0]      rate_q, rate_d;
  logic [SizeW-1:0] remain_q, remain_d;
  err_e             err_q, err_d;
  logic             warn_q, warn_d;
  logic             in_pay_q, in_pay_d;

  logic [31:0] shift_new;
  logic [15:0] half;

  always_comb begin
    pos_d    = start_i ? '0 : pos_q;
    shift_d  = start_i ? '0 : shift_q;
    chan_d   = start_i ? '0 : chan_q;
    width_d  = start_i ? '0 : width_q;
    rate_d   = start_i ? '0 : rate_q;
    remain_d = start_i ? '0 : remain_q;
    err_d    = start_i ? ERR_NONE : err_q;
    warn_d   = start_i ? 1'b0 : warn_q;
    in_pay_d = start_i ? 1'b0 : in_pay_q;

    shift_new = {in_byte_i, shift_d[31:8]};
    half      = shift_new[31:16];

    result_o               = '0;
    result_o.error_code    = ERR_NONE;

    if (err_d != ERR_NONE) begin
      result_o.payload_valid = 1'b0;
    end else if (in_pay_d) begin
      result_o.payload_valid = 1'b1;
      result_o.payload_byte  = in_byte_i;
      remain_d               = remain_d - SizeW'(1);
      if (remain_d == '0) begin
        result_o.payload_last = 1'b1;
        in_pay_d              = 1'b0;
      end
    end else if (pos_d < PosW'(HeaderLen)) begin
      shift_d = shift_new;
      case (pos_d)
        PosRiffEnd: begin
          if (shift_new != TagRiff) err_d = ERR_NO_RIFF;
        end
        PosWaveEnd: begin
          if (shift_new != TagWave) err_d = ERR_NO_WAVE;
        end
        PosFmtEnd: begin
          if (shift_new != TagFmt) err_d = ERR_NO_FMT;
        end
        PosFsizeEnd: begin
          if (shift_new != FmtSize) err_d = ERR_FMT_SIZE;
        end
        PosFtagEnd: begin
          if (half != FmtPcm) err_d = ERR_NOT_PCM;
        end
        PosChanEnd: begin
          chan_d = half;
        end
        PosRateEnd: begin
          rate_d = shift_new;
        end
        PosWidthEnd: begin
          width_d = half;
        end
        PosDtagEnd: begin
          if (shift_new != TagData) warn_d = 1'b1;
        end
        PosDsizeEnd: begin
          if (shift_new == '0 || shift_new[31]) begin
            err_d = ERR_DATA_SIZE;
          end else begin
            result_o.header_ok = 1'b1;
            result_o.data_size = shift_new[SizeW-1:0];
            remain_d           = shift_new[SizeW-1:0];
            in_pay_d           = 1'b1;
          end
        end
        default: begin
        end
      endcase
      pos_d = pos_d + PosW'(1);
    end

    result_o.error_code      = err_d;
    result_o.tag_warning     = warn_d;
    result_o.channels        = chan_d;
    result_o.bits_per_sample = width_d;
    result_o.sample_rate     = rate_d;
    result_o.format_code     = {chan_d != MonoCh, width_d != Width8};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      shift_q  <= '0;
      chan_q   <= '0;
      width_q  <= '0;
      rate_q   <= '0;
      remain_q <= '0;
      err_q    <= ERR_NONE;
      warn_q   <= 1'b0;
      in_pay_q <= 1'b0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      shift_q  <= shift_d;
      chan_q   <= chan_d;
      width_q  <= width_d;
      rate_q   <= rate_d;
      remain_q <= remain_d;
      err_q    <= err_d;
      warn_q   <= warn_d;
      in_pay_q <= in_pay_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(HeaderLen))
    else $error("header position ran past the header");
  a_pay_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pay_q |-> (err_q == ERR_NONE && pos_q == PosW'(HeaderLen)))
    else $error("payload phase without a clean header");
  a_pay_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pay_q |-> remain_q != '0)
    else $error("payload phase with no bytes left");
`endif

endmodule

### hw/rtl/wav_pcm_header_parser_unit.sv
// ----------------------------------------------------------------------------
// WAV PCM header parser unit
// Parses a RIFF/WAVE PCM header byte by byte and passes the payload through.
// ----------------------------------------------------------------------------
// Usage: file bytes enter on the s_axis channel, one byte per beat, with
// s_axis_tuser set on the first byte of a new file. Every input beat yields
// exactly one output beat on m_axis carrying the parse result for that byte.
// m_axis_tuser flags an audio payload byte and m_axis_tlast marks the final
// payload byte of the data chunk.
// The output beat follows in the cycle after its input beat is taken, and
// one byte can be taken every cycle. The rate is set by the single result
// register: a new byte is taken whenever that register is empty or is
// being drained. When the receiver stalls, the result is held and
// s_axis_tready stays low until the held beat is taken. Reset clears all
// parse state and the output valid flag; after reset a header is expected
// at byte 0 without a start flag. An error code is sticky and later bytes
// give non-payload results carrying the error until the next start flag.
// ----------------------------------------------------------------------------
module wav_pcm_header_parser_unit
  import wph_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // in_byte
  input  logic                s_axis_tuser,  // start_req
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // payload_byte, header_ok, error_code, tag_warning, channels,
  // bits_per_sample, sample_rate, data_size, format_code, zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tuser,  // payload_valid
  output logic                m_axis_tlast   // payload_last
);

  logic    out_valid_q;
  result_t res_q;
  result_t res_d;
  logic    accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  wph_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (accept),
    .in_byte_i (s_axis_tdata),
    .start_i   (s_axis_tuser),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.payload_valid;
  assign m_axis_tlast  = res_q.payload_last;
  assign m_axis_tdata  = {2'b00,
                          res_q.format_code,
                          res_q.data_size,
                          res_q.sample_rate,
                          res_q.bits_per_sample,
                          res_q.channels,
                          res_q.tag_warning,
                          res_q.error_code,
                          res_q.header_ok,
                          res_q.payload_byte};

`ifndef NO_ASSERTIONS
  a_last_is_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("last flag on a beat that is not payload");
  a_ok_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.header_ok) |-> (res_q.error_code == ERR_NONE))
    else $error("header accepted together with an error");
  a_size_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res_q.header_ok) |-> (res_q.data_size == '0))
    else $error("data size shown outside the header completion beat");
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted byte produced no result beat");
`endif

endmodule
